@@ rtl/ckf_pkg.sv @@
// Package for the connection keep-alive state machine.
// Holds state, action and result codes, shared structs and code conversion.
// No dependencies.
package ckf_pkg;

  // Default widths and reset values
  localparam int unsigned AGE_BITS_DEF = 32;
  localparam int unsigned CFG_W = 31;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);

  localparam logic [CFG_W-1:0] CONNECT_TIMEOUT_RST = CFG_W'(10000);
  localparam logic [CFG_W-1:0] KA_INTERVAL_RST = CFG_W'(2000);
  localparam logic [CFG_W-1:0] ANSWER_TIMEOUT_RST = CFG_W'(5000);

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_CONNECT_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_IDX_KA_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_IDX_ANSWER_TIMEOUT = 2'd2;

  // Disconnect causes with a fixed meaning
  localparam logic [2:0] CAUSE_CLOSED = 3'd0;
  localparam logic [2:0] CAUSE_LOST = 3'd1;

  // Internal one-hot connection state
  typedef enum logic [8:0] {
    ST_IDLE         = 9'b000000001,
    ST_CONNECTING   = 9'b000000010,
    ST_CONNECTED    = 9'b000000100,
    ST_BAD_PW       = 9'b000001000,
    ST_MAX_CONNS    = 9'b000010000,
    ST_BAD_PACKET   = 9'b000100000,
    ST_INIT_TIMEOUT = 9'b001000000,
    ST_DISCONNECTED = 9'b010000000,
    ST_TIMED_OUT    = 9'b100000000
  } state_e;

  // Externally visible state codes
  typedef enum logic [3:0] {
    SC_IDLE         = 4'd0,
    SC_CONNECTING   = 4'd1,
    SC_CONNECTED    = 4'd2,
    SC_BAD_PW       = 4'd3,
    SC_MAX_CONNS    = 4'd4,
    SC_BAD_PACKET   = 4'd5,
    SC_INIT_TIMEOUT = 4'd6,
    SC_DISCONNECTED = 4'd7,
    SC_TIMED_OUT    = 4'd8
  } state_code_e;

  typedef enum logic [3:0] {
    ACT_TICK          = 4'd0,
    ACT_START_CONNECT = 4'd1,
    ACT_ACCEPT_IN     = 4'd2,
    ACT_RX_ACCEPT     = 4'd3,
    ACT_RX_DISCONNECT = 4'd4,
    ACT_RX_KA_REQ     = 4'd5,
    ACT_RX_KA_ANSWER  = 4'd6,
    ACT_RX_BAD_PW     = 4'd7,
    ACT_RX_MAX_CONNS  = 4'd8,
    ACT_RX_BAD_CONN   = 4'd9,
    ACT_LOCAL_DISC    = 4'd10,
    ACT_SEND_KA_ANS   = 4'd11,
    ACT_SEND_KA_REQ   = 4'd12
  } action_e;

  typedef enum logic [1:0] {
    RK_PACKET     = 2'd0,
    RK_CONNECT    = 2'd1,
    RK_DISCONNECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PKT_CONN_REQ    = 3'd0,
    PKT_CONN_ACCEPT = 3'd1,
    PKT_DISCONNECT  = 3'd2,
    PKT_KA_REQ      = 3'd3,
    PKT_KA_ANSWER   = 3'd4
  } pkt_e;

  typedef enum logic [2:0] {
    OUT_SUCCESS   = 3'd0,
    OUT_TIMED_OUT = 3'd1,
    OUT_BAD_PW    = 3'd2,
    OUT_MAX_CONNS = 3'd3,
    OUT_BAD_CONN  = 3'd4
  } outcome_e;

  // One input word
  typedef struct packed {
    logic [3:0] action;
    logic [3:0] target_state;
    logic [2:0] cause;
    logic       notify_peer;
    logic       direct_flag;
  } item_t;

  // Configuration registers
  typedef struct packed {
    logic [CFG_W-1:0] connect_timeout;
    logic [CFG_W-1:0] ka_interval;
    logic [CFG_W-1:0] answer_timeout;
  } cfg_t;

  // One result word
  typedef struct packed {
    kind_e       kind;
    pkt_e        pkt;
    outcome_e    outc;
    logic [2:0]  dcause;
    logic        dir;
    state_code_e state;
    logic        last;
  } res_t;

  // Results of one step, pushed into the result queue
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic state_code_e state_to_code(state_e s);
    state_code_e c;
    unique case (s)
      ST_IDLE:         c = SC_IDLE;
      ST_CONNECTING:   c = SC_CONNECTING;
      ST_CONNECTED:    c = SC_CONNECTED;
      ST_BAD_PW:       c = SC_BAD_PW;
      ST_MAX_CONNS:    c = SC_MAX_CONNS;
      ST_BAD_PACKET:   c = SC_BAD_PACKET;
      ST_INIT_TIMEOUT: c = SC_INIT_TIMEOUT;
      ST_DISCONNECTED: c = SC_DISCONNECTED;
      ST_TIMED_OUT:    c = SC_TIMED_OUT;
      default:         c = SC_IDLE;
    endcase
    return c;
  endfunction

  // Codes above the last state map to disconnected
  function automatic state_e code_to_state(logic [3:0] code);
    state_e s;
    unique case (state_code_e'(code))
      SC_IDLE:         s = ST_IDLE;
      SC_CONNECTING:   s = ST_CONNECTING;
      SC_CONNECTED:    s = ST_CONNECTED;
      SC_BAD_PW:       s = ST_BAD_PW;
      SC_MAX_CONNS:    s = ST_MAX_CONNS;
      SC_BAD_PACKET:   s = ST_BAD_PACKET;
      SC_INIT_TIMEOUT: s = ST_INIT_TIMEOUT;
      SC_DISCONNECTED: s = ST_DISCONNECTED;
      SC_TIMED_OUT:    s = ST_TIMED_OUT;
      default:         s = ST_DISCONNECTED;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/ckf_step.sv @@
// Connection state registers and the single-pass step logic for one word.
// Depends on ckf_pkg.
module ckf_step import ckf_pkg::*; #(
  parameter int unsigned AgeBits = AGE_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output push_t push_o
);

  localparam int unsigned CmpW = (AgeBits > CFG_W) ? AgeBits : CFG_W;

  state_e             st_q, st_d;
  logic [AgeBits-1:0] cage_q, cage_d, cage_inc;
  logic [AgeBits-1:0] kage_q, kage_d, kage_inc;
  logic               await_q, await_d;
  logic               done_q, done_d;
  logic               link_q, link_d;

  logic [CmpW-1:0] cage_ext, kage_ext, cto_ext, kai_ext, ato_ext;

  logic        send_req, send_vld;
  pkt_e        send_pkt;
  logic        rep_vld;
  kind_e       rep_kind;
  outcome_e    rep_outc;
  logic [2:0]  rep_cause;
  logic        rep_dir;
  logic        disc_req;
  logic        disc_dir;
  logic [2:0]  disc_cause;
  state_e      disc_tgt;
  logic        disc_notify;
  res_t        send_res, rep_res;
  state_code_e st_code;

  // Saturating age increments
  assign cage_inc = (&cage_q) ? cage_q : cage_q + AgeBits'(1);
  assign kage_inc = (&kage_q) ? kage_q : kage_q + AgeBits'(1);

  assign cage_ext = CmpW'(cage_inc);
  assign kage_ext = CmpW'(kage_inc);
  assign cto_ext  = CmpW'(cfg_i.connect_timeout);
  assign kai_ext  = CmpW'(cfg_i.ka_interval);
  assign ato_ext  = CmpW'(cfg_i.answer_timeout);

  // Decode the word against the current state
  always_comb begin
    st_d        = st_q;
    cage_d      = cage_q;
    kage_d      = kage_q;
    await_d     = await_q;
    done_d      = done_q;
    link_d      = link_q;
    send_req    = 1'b0;
    send_pkt    = PKT_CONN_REQ;
    rep_vld     = 1'b0;
    rep_kind    = RK_CONNECT;
    rep_outc    = OUT_SUCCESS;
    rep_cause   = CAUSE_CLOSED;
    rep_dir     = 1'b0;
    disc_req    = 1'b0;
    disc_dir    = 1'b0;
    disc_cause  = CAUSE_CLOSED;
    disc_tgt    = ST_DISCONNECTED;
    disc_notify = 1'b0;

    if (fire_i) begin
      unique case (action_e'(item_i.action))
        ACT_TICK: begin
          cage_d = cage_inc;
          kage_d = kage_inc;
          if (st_q == ST_CONNECTING) begin
            if (cage_ext >= cto_ext) begin
              st_d     = ST_INIT_TIMEOUT;
              rep_vld  = 1'b1;
              rep_kind = RK_CONNECT;
              rep_outc = OUT_TIMED_OUT;
              link_d   = 1'b0;
            end
          end else if (st_q == ST_CONNECTED && cfg_i.ka_interval != '0) begin
            if (!await_q) begin
              if (kage_ext > kai_ext) begin
                kage_d   = '0;
                send_req = 1'b1;
                send_pkt = PKT_KA_REQ;
                await_d  = 1'b1;
              end
            end else if (kage_ext > ato_ext) begin
              disc_req   = 1'b1;
              disc_dir   = 1'b1;
              disc_cause = CAUSE_LOST;
              disc_tgt   = ST_TIMED_OUT;
            end
          end
        end
        ACT_START_CONNECT: begin
          if (st_q == ST_IDLE) begin
            st_d     = ST_CONNECTING;
            cage_d   = '0;
            send_req = 1'b1;
            send_pkt = PKT_CONN_REQ;
          end
        end
        ACT_ACCEPT_IN: begin
          if (st_q == ST_IDLE) begin
            st_d     = ST_CONNECTED;
            send_req = 1'b1;
            send_pkt = PKT_CONN_ACCEPT;
          end
        end
        ACT_RX_ACCEPT: begin
          if (st_q == ST_CONNECTING) begin
            st_d     = ST_CONNECTED;
            kage_d   = '0;
            rep_vld  = 1'b1;
            rep_kind = RK_CONNECT;
            rep_outc = OUT_SUCCESS;
          end
        end
        ACT_RX_DISCONNECT: begin
          if (st_q == ST_CONNECTED) begin
            disc_req   = 1'b1;
            disc_dir   = 1'b1;
            disc_cause = CAUSE_CLOSED;
            disc_tgt   = ST_DISCONNECTED;
          end
        end
        ACT_RX_KA_REQ, ACT_SEND_KA_ANS: begin
          if (st_q == ST_CONNECTED) begin
            send_req = 1'b1;
            send_pkt = PKT_KA_ANSWER;
          end
        end
        ACT_RX_KA_ANSWER: begin
          if (await_q) begin
            await_d = 1'b0;
            kage_d  = '0;
          end
        end
        ACT_RX_BAD_PW: begin
          if (st_q == ST_CONNECTING) begin
            st_d     = ST_BAD_PW;
            rep_vld  = 1'b1;
            rep_kind = RK_CONNECT;
            rep_outc = OUT_BAD_PW;
          end
        end
        ACT_RX_MAX_CONNS: begin
          if (st_q == ST_CONNECTING) begin
            st_d     = ST_MAX_CONNS;
            rep_vld  = 1'b1;
            rep_kind = RK_CONNECT;
            rep_outc = OUT_MAX_CONNS;
          end
        end
        ACT_RX_BAD_CONN: begin
          if (st_q == ST_CONNECTING) begin
            st_d     = ST_BAD_PACKET;
            rep_vld  = 1'b1;
            rep_kind = RK_CONNECT;
            rep_outc = OUT_BAD_CONN;
          end
        end
        ACT_LOCAL_DISC: begin
          disc_req    = 1'b1;
          disc_dir    = item_i.direct_flag;
          disc_cause  = item_i.cause;
          disc_tgt    = code_to_state(item_i.target_state);
          disc_notify = item_i.notify_peer;
        end
        ACT_SEND_KA_REQ: begin
          if (st_q == ST_CONNECTED) begin
            kage_d   = '0;
            send_req = 1'b1;
            send_pkt = PKT_KA_REQ;
          end
        end
        default: begin
        end
      endcase
    end

    // Only the first disconnect takes effect; it reports only from connected
    if (disc_req && !done_q) begin
      done_d = 1'b1;
      if (st_q == ST_CONNECTED) begin
        if (disc_notify) begin
          send_req = 1'b1;
          send_pkt = PKT_DISCONNECT;
        end
        rep_vld   = 1'b1;
        rep_kind  = RK_DISCONNECT;
        rep_cause = disc_cause;
        rep_dir   = disc_dir;
      end
      st_d   = disc_tgt;
      link_d = 1'b0;
    end
  end

  // Drop packet sends once the link is cleaned
  assign send_vld = send_req && link_q;
  assign st_code  = state_to_code(st_d);

  always_comb begin
    send_res        = '0;
    send_res.kind   = RK_PACKET;
    send_res.pkt    = send_pkt;
    send_res.outc   = OUT_SUCCESS;
    send_res.state  = st_code;
    send_res.last   = !rep_vld;

    rep_res         = '0;
    rep_res.kind    = rep_kind;
    rep_res.pkt     = PKT_CONN_REQ;
    rep_res.outc    = (rep_kind == RK_CONNECT) ? rep_outc : OUT_SUCCESS;
    rep_res.dcause  = (rep_kind == RK_DISCONNECT) ? rep_cause : CAUSE_CLOSED;
    rep_res.dir     = (rep_kind == RK_DISCONNECT) ? rep_dir : 1'b0;
    rep_res.state   = st_code;
    rep_res.last    = 1'b1;
  end

  // Send goes first, report after it
  always_comb begin
    push_o.n  = 2'({1'b0, send_vld}) + 2'({1'b0, rep_vld});
    push_o.r0 = send_vld ? send_res : rep_res;
    push_o.r1 = rep_res;
  end

  // Hold the connection state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      cage_q  <= '0;
      kage_q  <= '1;
      await_q <= 1'b0;
      done_q  <= 1'b0;
      link_q  <= 1'b1;
    end else begin
      st_q    <= st_d;
      cage_q  <= cage_d;
      kage_q  <= kage_d;
      await_q <= await_d;
      done_q  <= done_d;
      link_q  <= link_d;
    end
  end

`ifndef SYNTHESIS
  a_done_no_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !link_q)
    else $error("link present after disconnect");

  a_start_clears_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.action == ACT_START_CONNECT && st_q == ST_IDLE)
      |=> (cage_q == '0 && st_q == ST_CONNECTING))
    else $error("connect start did not clear age");

  a_accept_clears_ka: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.action == ACT_RX_ACCEPT && st_q == ST_CONNECTING)
      |=> (kage_q == '0 && st_q == ST_CONNECTED))
    else $error("rx accept did not enter connected with fresh age");
`endif

endmodule

@@ rtl/ckf_res_fifo.sv @@
// Result queue: takes up to two result words per cycle, hands out one per cycle while out_ready_i is high.
// Depends on ckf_pkg.
module ckf_res_fifo import ckf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room2_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  head_o
);

  localparam int unsigned CntW = RES_PTR_W + 1;

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_q, rd_q, wr_nxt;
  logic [CntW-1:0]      cnt_q;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room2_o     = (cnt_q <= CntW'(RES_DEPTH - 2));
  assign wr_nxt      = wr_q + RES_PTR_W'(1);

  // Write up to two words
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + RES_PTR_W'(push_i.n);
      rd_q  <= rd_q + RES_PTR_W'(pop);
      cnt_q <= cnt_q + CntW'(push_i.n) - CntW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> room2_o)
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RES_DEPTH))
    else $error("result count beyond depth");

  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n == 2'd2) |-> (!push_i.r0.last && push_i.r1.last))
    else $error("bad last marking on a two-word push");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n == 2'd1) |-> push_i.r0.last)
    else $error("single word push without last");
`endif

endmodule

@@ rtl/connection_keepalive_fsm.sv @@
// Connection keep-alive state machine, top level; uses ckf_pkg, ckf_step and ckf_res_fifo.
// An accepted word waits in the input register and is processed once the result queue has
// room for two words; with the queue empty, its first result is valid right after that.
// Throughput: one input word per cycle while the queue has room; one result word out per
// cycle while out_ready_i is high, a second result following the first; input stalls while three or more words wait.
// Reset: asynchronous, active low; state idle, keep-alive age saturated, config defaults.
module connection_keepalive_fsm import ckf_pkg::*; #(
  parameter int unsigned AgeBits = AGE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [3:0]       action_i,
  input  logic [3:0]       target_state_i,
  input  logic [2:0]       cause_i,
  input  logic             notify_peer_i,
  input  logic             direct_flag_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [2:0]       packet_type_o,
  output logic [2:0]       connect_outcome_o,
  output logic [2:0]       disconnect_cause_o,
  output logic             direct_out_o,
  output logic [3:0]       conn_state_o,
  output logic             last_o
);

  cfg_t  cfg_q;
  item_t item_q;
  logic  stg_vld_q;
  logic  room2;
  logic  fire;
  push_t push;
  res_t  head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.connect_timeout <= CONNECT_TIMEOUT_RST;
      cfg_q.ka_interval     <= KA_INTERVAL_RST;
      cfg_q.answer_timeout  <= ANSWER_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_CONNECT_TIMEOUT: cfg_q.connect_timeout <= cfg_wdata_i;
        CFG_IDX_KA_INTERVAL:     cfg_q.ka_interval     <= cfg_wdata_i;
        CFG_IDX_ANSWER_TIMEOUT:  cfg_q.answer_timeout  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Input register: process when the result queue can take two words
  assign fire       = stg_vld_q && room2;
  assign in_ready_o = !stg_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.action       <= action_i;
      item_q.target_state <= target_state_i;
      item_q.cause        <= cause_i;
      item_q.notify_peer  <= notify_peer_i;
      item_q.direct_flag  <= direct_flag_i;
    end
  end

  ckf_step #(
    .AgeBits(AgeBits)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .push_o (push)
  );

  ckf_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  // Unpack the head result word
  assign result_kind_o      = head.kind;
  assign packet_type_o      = head.pkt;
  assign connect_outcome_o  = head.outc;
  assign disconnect_cause_o = head.dcause;
  assign direct_out_o       = head.dir;
  assign conn_state_o       = head.state;
  assign last_o             = head.last;

`ifndef SYNTHESIS
  a_push_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0) |-> fire)
    else $error("result pushed without a processed word");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_vld_q && !fire) |=> (stg_vld_q && $stable(item_q)))
    else $error("stalled input word lost");

  a_no_result_on_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_q.action > ACT_SEND_KA_REQ) |-> (push.n == 2'd0))
    else $error("result from an unused action code");
`endif

endmodule
